[rtl/eyvm_pkg.sv]
// shared types, constants and rounding helpers for the euler view matrix pipeline
`timescale 1ns / 1ps
package eyvm_pkg;

  // sine polynomial coefficients, q14
  localparam int SIN_A   = 25736;
  localparam int SIN_B   = 10512;
  localparam int SIN_C   = 1160;
  localparam int ONE_Q14 = 16384;

  // register stages from accepted beat to output register
  localparam int NSTAGE = 9;

  typedef logic [NSTAGE-1:0] stage_en_t;

  typedef struct packed {
    logic signed [15:0] row0_x;
    logic signed [15:0] row0_y;
    logic signed [15:0] row0_z;
    logic signed [15:0] row1_x;
    logic signed [15:0] row1_y;
    logic signed [15:0] row1_z;
    logic signed [15:0] row2_x;
    logic signed [15:0] row2_y;
    logic signed [15:0] row2_z;
  } mat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

  // q42 sum to q14, round half up, clamp to plus or minus one
  function automatic logic signed [15:0] round_row(input logic signed [47:0] v);
    logic signed [47:0] b;
    logic signed [19:0] r;
    begin
      b = v + 48'sd134217728;
      r = 20'(b >>> 28);
      if (r > 20'sd16384) begin
        round_row = 16'sd16384;
      end else if (r < -20'sd16384) begin
        round_row = -16'sd16384;
      end else begin
        round_row = 16'(r);
      end
    end
  endfunction

  // negated q30 dot product to q16.16, round half up, saturate
  function automatic logic signed [31:0] make_shift(input logic signed [49:0] d);
    logic signed [51:0] n;
    logic signed [37:0] r;
    begin
      n = -52'(d) + 52'sd8192;
      r = 38'(n >>> 14);
      if (r > 38'sd2147483647) begin
        make_shift = 32'sh7fffffff;
      end else if (r < -38'sd2147483648) begin
        make_shift = 32'sh80000000;
      end else begin
        make_shift = 32'(r);
      end
    end
  endfunction

endpackage

[rtl/eyvm_if.sv]
// handshake channels for pose beats and view matrix beats
`timescale 1ns / 1ps
interface eyvm_pose_if;
  logic               valid;
  logic               ready;
  logic        [15:0] pitch_angle;
  logic        [15:0] yaw_angle;
  logic        [15:0] roll_angle;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, pitch_angle, yaw_angle, roll_angle, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, pitch_angle, yaw_angle, roll_angle, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface eyvm_view_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] row0_x;
  logic signed [15:0] row0_y;
  logic signed [15:0] row0_z;
  logic signed [15:0] row1_x;
  logic signed [15:0] row1_y;
  logic signed [15:0] row1_z;
  logic signed [15:0] row2_x;
  logic signed [15:0] row2_y;
  logic signed [15:0] row2_z;
  logic signed [31:0] shift_x;
  logic signed [31:0] shift_y;
  logic signed [31:0] shift_z;

  modport source (output valid, row0_x, row0_y, row0_z, row1_x, row1_y, row1_z,
                  row2_x, row2_y, row2_z, shift_x, shift_y, shift_z, input ready);
  modport sink (input valid, row0_x, row0_y, row0_z, row1_x, row1_y, row1_z,
                row2_x, row2_y, row2_z, shift_x, shift_y, shift_z, output ready);
endinterface

[rtl/eyvm_sine.sv]
// four stage pipelined polynomial sine of a binary angle, q14 result
`timescale 1ns / 1ps
module eyvm_sine (
  input  logic               clk,
  input  logic         [3:0] en,
  input  logic        [15:0] angle,
  output logic signed [15:0] value
);

  logic [14:0] x_c;
  logic [29:0] sq_c;
  logic [14:0] x0, x20;
  logic [1:0]  quad0;
  logic [25:0] m1_c;
  logic [13:0] yb1;
  logic [14:0] x1, x21;
  logic [1:0]  quad1;
  logic [28:0] m2_c;
  logic [14:0] ya2;
  logic [14:0] x2;
  logic [1:0]  quad2;
  logic [29:0] m3_c;
  logic [15:0] mag_c;

  // odd quadrants mirror the angle
  always_comb begin
    if (angle[14]) begin
      x_c = 15'(eyvm_pkg::ONE_Q14) - {1'b0, angle[13:0]};
    end else begin
      x_c = {1'b0, angle[13:0]};
    end
    sq_c = 30'(x_c) * 30'(x_c);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0    <= x_c;
      x20   <= sq_c[28:14];
      quad0 <= angle[15:14];
    end
  end

  assign m1_c = 26'(eyvm_pkg::SIN_C) * 26'(x20);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      yb1   <= 14'(eyvm_pkg::SIN_B) - 14'(m1_c[25:14]);
      x1    <= x0;
      x21   <= x20;
      quad1 <= quad0;
    end
  end

  assign m2_c = 29'(yb1) * 29'(x21);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ya2   <= 15'(eyvm_pkg::SIN_A) - m2_c[28:14];
      x2    <= x1;
      quad2 <= quad1;
    end
  end

  always_comb begin
    m3_c = 30'(ya2) * 30'(x2);
    if (m3_c[29:14] > 16'(eyvm_pkg::ONE_Q14)) begin
      mag_c = 16'(eyvm_pkg::ONE_Q14);
    end else begin
      mag_c = m3_c[29:14];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      value <= quad2[1] ? -$signed(mag_c) : $signed(mag_c);
    end
  end

endmodule

[rtl/eyvm_rows.sv]
// rotation rows: pair products, triple products, then q14 rounding
`timescale 1ns / 1ps
module eyvm_rows (
  input  logic                 clk,
  input  logic           [2:0] en,
  input  logic signed   [15:0] s1,
  input  logic signed   [15:0] c1,
  input  logic signed   [15:0] s2,
  input  logic signed   [15:0] c2,
  input  logic signed   [15:0] s3,
  input  logic signed   [15:0] c3,
  output eyvm_pkg::mat_t       mat
);

  logic signed [31:0] p_c1c3, p_s1s2, p_c2s3, p_c1s2, p_c3s1;
  logic signed [31:0] p_c1s3, p_c2c3, p_s1s3, p_c2s1, p_c1c2;
  logic signed [15:0] s2_a, s3_a, c3_a;

  logic signed [47:0] t_s1s2s3, t_c1s2s3, t_c3s1s2, t_c1c3s2;
  logic signed [31:0] q_c1c3, q_c2s3, q_c3s1, q_c1s3, q_c2c3, q_s1s3, q_c2s1, q_c1c2;
  logic signed [15:0] s2_b;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_c1c3 <= c1 * c3;
      p_s1s2 <= s1 * s2;
      p_c2s3 <= c2 * s3;
      p_c1s2 <= c1 * s2;
      p_c3s1 <= c3 * s1;
      p_c1s3 <= c1 * s3;
      p_c2c3 <= c2 * c3;
      p_s1s3 <= s1 * s3;
      p_c2s1 <= c2 * s1;
      p_c1c2 <= c1 * c2;
      s2_a   <= s2;
      s3_a   <= s3;
      c3_a   <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_s1s2s3 <= 48'(p_s1s2) * 48'(s3_a);
      t_c1s2s3 <= 48'(p_c1s2) * 48'(s3_a);
      t_c3s1s2 <= 48'(p_s1s2) * 48'(c3_a);
      t_c1c3s2 <= 48'(p_c1c3) * 48'(s2_a);
      q_c1c3   <= p_c1c3;
      q_c2s3   <= p_c2s3;
      q_c3s1   <= p_c3s1;
      q_c1s3   <= p_c1s3;
      q_c2c3   <= p_c2c3;
      q_s1s3   <= p_s1s3;
      q_c2s1   <= p_c2s1;
      q_c1c2   <= p_c1c2;
      s2_b     <= s2_a;
    end
  end

  // pair terms move up by 2^14 to join the triple terms in q42
  always_ff @(posedge clk) begin
    if (en[2]) begin
      mat.row0_x <= eyvm_pkg::round_row((48'(q_c1c3) <<< 14) + t_s1s2s3);
      mat.row0_y <= eyvm_pkg::round_row(48'(q_c2s3) <<< 14);
      mat.row0_z <= eyvm_pkg::round_row(t_c1s2s3 - (48'(q_c3s1) <<< 14));
      mat.row1_x <= eyvm_pkg::round_row(t_c3s1s2 - (48'(q_c1s3) <<< 14));
      mat.row1_y <= eyvm_pkg::round_row(48'(q_c2c3) <<< 14);
      mat.row1_z <= eyvm_pkg::round_row(t_c1c3s2 + (48'(q_s1s3) <<< 14));
      mat.row2_x <= eyvm_pkg::round_row(48'(q_c2s1) <<< 14);
      mat.row2_y <= -s2_b;
      mat.row2_z <= eyvm_pkg::round_row(48'(q_c1c2) <<< 14);
    end
  end

endmodule

[rtl/eyvm_shift.sv]
// translation: row by position products, then sum, round and saturate
`timescale 1ns / 1ps
module eyvm_shift (
  input  logic                 clk,
  input  logic           [1:0] en,
  input  eyvm_pkg::mat_t       mat,
  input  eyvm_pkg::pos_t       pos,
  output eyvm_pkg::mat_t       mat_q,
  output logic signed   [31:0] shift_x,
  output logic signed   [31:0] shift_y,
  output logic signed   [31:0] shift_z
);

  logic signed [47:0] p00, p01, p02, p10, p11, p12, p20, p21, p22;
  eyvm_pkg::mat_t     mat_p;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p00   <= 48'(mat.row0_x) * 48'(pos.x);
      p01   <= 48'(mat.row0_y) * 48'(pos.y);
      p02   <= 48'(mat.row0_z) * 48'(pos.z);
      p10   <= 48'(mat.row1_x) * 48'(pos.x);
      p11   <= 48'(mat.row1_y) * 48'(pos.y);
      p12   <= 48'(mat.row1_z) * 48'(pos.z);
      p20   <= 48'(mat.row2_x) * 48'(pos.x);
      p21   <= 48'(mat.row2_y) * 48'(pos.y);
      p22   <= 48'(mat.row2_z) * 48'(pos.z);
      mat_p <= mat;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      shift_x <= eyvm_pkg::make_shift(50'(p00) + 50'(p01) + 50'(p02));
      shift_y <= eyvm_pkg::make_shift(50'(p10) + 50'(p11) + 50'(p12));
      shift_z <= eyvm_pkg::make_shift(50'(p20) + 50'(p21) + 50'(p22));
      mat_q   <= mat_p;
    end
  end

endmodule

[rtl/euler_yxz_view_matrix_top.sv]
// Y-X-Z Euler view matrix generator. One pose beat (three 16-bit binary
// angles, camera position in Q16.16) gives one view beat: nine rotation
// entries in Q2.14 and three saturated Q16.16 translations. The pipeline is
// nine register stages deep: four for the polynomial sine units, three for
// the rotation products and rounding, two for the translation products and
// their sum. A beat is taken every cycle unless a stall reaches the first
// stage, so throughput is one beat per cycle; when the output is stalled,
// empty stages still fill, and the block keeps no state between beats.
`timescale 1ns / 1ps
module euler_yxz_view_matrix_top (
  input  logic              clk,
  input  logic              rst,
  eyvm_pose_if.sink         pose,
  eyvm_view_if.source       view
);

  localparam int N = eyvm_pkg::NSTAGE;

  logic [N-1:0]          v;
  eyvm_pkg::stage_en_t   en;
  eyvm_pkg::pos_t        pos_d [0:6];
  eyvm_pkg::pos_t        pos_in;
  logic signed [15:0]    s1, c1, s2, c2, s3, c3;
  eyvm_pkg::mat_t        mat, mat_q;

  // a stage loads when it is empty or the one after it moves on
  always_comb begin
    en[N-1] = !v[N-1] || view.ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign pose.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pose.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign pos_in = '{x: pose.pos_x, y: pose.pos_y, z: pose.pos_z};

  // position rides alongside the sine and rotation stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pos_d[0] <= pos_in;
    end
    for (int k = 1; k < 7; k++) begin
      if (en[k]) begin
        pos_d[k] <= pos_d[k-1];
      end
    end
  end

  eyvm_sine u_sin_pitch (.clk(clk), .en(en[3:0]), .angle(pose.pitch_angle), .value(s2));
  eyvm_sine u_cos_pitch (.clk(clk), .en(en[3:0]),
                         .angle(pose.pitch_angle + 16'(eyvm_pkg::ONE_Q14)), .value(c2));
  eyvm_sine u_sin_yaw   (.clk(clk), .en(en[3:0]), .angle(pose.yaw_angle), .value(s1));
  eyvm_sine u_cos_yaw   (.clk(clk), .en(en[3:0]),
                         .angle(pose.yaw_angle + 16'(eyvm_pkg::ONE_Q14)), .value(c1));
  eyvm_sine u_sin_roll  (.clk(clk), .en(en[3:0]), .angle(pose.roll_angle), .value(s3));
  eyvm_sine u_cos_roll  (.clk(clk), .en(en[3:0]),
                         .angle(pose.roll_angle + 16'(eyvm_pkg::ONE_Q14)), .value(c3));

  eyvm_rows u_rows (
    .clk (clk),
    .en  (en[6:4]),
    .s1  (s1),
    .c1  (c1),
    .s2  (s2),
    .c2  (c2),
    .s3  (s3),
    .c3  (c3),
    .mat (mat)
  );

  eyvm_shift u_shift (
    .clk     (clk),
    .en      (en[8:7]),
    .mat     (mat),
    .pos     (pos_d[6]),
    .mat_q   (mat_q),
    .shift_x (view.shift_x),
    .shift_y (view.shift_y),
    .shift_z (view.shift_z)
  );

  assign view.valid  = v[N-1];
  assign view.row0_x = mat_q.row0_x;
  assign view.row0_y = mat_q.row0_y;
  assign view.row0_z = mat_q.row0_z;
  assign view.row1_x = mat_q.row1_x;
  assign view.row1_y = mat_q.row1_y;
  assign view.row1_z = mat_q.row1_z;
  assign view.row2_x = mat_q.row2_x;
  assign view.row2_y = mat_q.row2_y;
  assign view.row2_z = mat_q.row2_z;

endmodule

[rtl/eyvm_checker.sv]
// port level checks for the view matrix pipeline, bound to the top level
`timescale 1ns / 1ps
module eyvm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] row2_y,
  input logic signed [31:0] shift_x
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("view beat valid straight after reset");

  // an empty output register means the whole pipe can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pose not taken while output is empty");

  // a stalled view beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row2_y) && $stable(shift_x))
    else $error("stalled view beat changed");

  // the rotation entry row2_y stays within one
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (row2_y <= 16'sd16384) && (row2_y >= -16'sd16384))
    else $error("rotation entry out of range");

endmodule

bind euler_yxz_view_matrix_top eyvm_checker u_eyvm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pose.ready),
  .out_valid (view.valid),
  .out_ready (view.ready),
  .row2_y    (view.row2_y),
  .shift_x   (view.shift_x)
);
